### src/assert_macros.svh
// Assertion macro used by the heap top-level RTL.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property check, muted while in reset.
`define HMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`endif

### src/hmh_pkg.sv
// Shared types, constants and helpers of the five-way min-heap.
// No dependencies.
`timescale 1ns / 1ps
package hmh_pkg;
    localparam int CAPACITY = 512;
    localparam int ADDR_W   = 9;
    localparam int CNT_W    = 10;
    localparam int VAL_W    = 31;
    localparam int FIRST_W  = 12;
    localparam int OFF_W    = 3;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMIN = 2'd1;
    localparam logic [1:0] CMD_DELMAX = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic             vld;
        logic [VAL_W-1:0] val;
        logic [OFF_W-1:0] off;
    } t_best;

    // x / 5 for x < 512
    function automatic logic [ADDR_W-1:0] div5(input logic [ADDR_W-1:0] x);
        logic [ADDR_W+7:0] p;
        p = {8'd0, x} * (ADDR_W+8)'(205);
        return ADDR_W'(p[ADDR_W+7:10]);
    endfunction
endpackage

### src/hmh_cell.sv
// One child-slot cell: holds a child value, shifts it on, and keeps the
// running smallest child along the chain. Depends on hmh_pkg.
`timescale 1ns / 1ps
module hmh_cell import hmh_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [VAL_W-1:0] i_val,
    input  logic             i_vld,
    input  logic [OFF_W-1:0] i_off,
    output logic [VAL_W-1:0] o_val,
    output logic             o_vld,
    output logic [OFF_W-1:0] o_off,
    input  t_best            i_best,
    output t_best            o_best
);
    logic [VAL_W-1:0] r_val;
    logic             r_vld;
    logic [OFF_W-1:0] r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_vld;
        end
        if (i_shift) begin
            r_val <= i_val;
            r_off <= i_off;
        end
    end

    // earlier child wins ties
    always_comb begin
        if (r_vld && (!i_best.vld || r_val < i_best.val)) begin
            o_best = '{vld: 1'b1, val: r_val, off: r_off};
        end else begin
            o_best = i_best;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;
    assign o_off = r_off;
endmodule

### src/five_ary_min_heap.sv
// Five-way min-heap priority queue of 512 positive 31-bit values: one
// command in, one result out. Depends on hmh_pkg, hmh_cell, assert_macros.svh.
`timescale 1ns / 1ps
// One command at a time. All work goes through a store with one write port
// and a registered read port: insert reads and writes once per level climbed;
// delete-min reads the five children of each level descended (shifted through a
// row of five compare cells); delete-max scans the leaves, then does the
// sift-up; remove visits each slot and sifts once per hit; every command
// ends by reading the root and posting the result. No clearing pass:
// the entry count marks the valid slots.
module five_ary_min_heap import hmh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[30:0], pad
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata    // status, min_value, removed_value,
                                        // removed_count, entry_count, pad
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_UP    = 5'd1;
    localparam logic [4:0] S_UP_W  = 5'd2;
    localparam logic [4:0] S_DN    = 5'd3;
    localparam logic [4:0] S_DN_R  = 5'd4;
    localparam logic [4:0] S_DN_L  = 5'd5;
    localparam logic [4:0] S_DN_C  = 5'd6;
    localparam logic [4:0] S_DM_R0 = 5'd7;
    localparam logic [4:0] S_DM_W0 = 5'd8;
    localparam logic [4:0] S_DM_W1 = 5'd9;
    localparam logic [4:0] S_MX_R  = 5'd10;
    localparam logic [4:0] S_MX_W  = 5'd11;
    localparam logic [4:0] S_MX_E  = 5'd12;
    localparam logic [4:0] S_RM_R  = 5'd13;
    localparam logic [4:0] S_RM_W  = 5'd14;
    localparam logic [4:0] S_RM_L  = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;
    localparam logic [4:0] S_FIN_W = 5'd17;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_wa, rd_addr;
    logic [VAL_W-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    logic [4:0]        r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [VAL_W-1:0]  r_val, n_val, r_v, n_v, r_mx, n_mx, r_removed, n_removed;
    logic [CNT_W-1:0]  r_count, n_count, r_rcount, n_rcount, r_scan, n_scan;
    logic [ADDR_W-1:0] r_pos, n_pos, r_par, n_par, r_spot, n_spot;
    logic [2:0]        r_status, n_status;
    logic              r_moved, n_moved;
    logic [OFF_W-1:0]  r_k, n_k, r_coff, n_coff;
    logic              r_shv, n_shv, r_cv, n_cv;
    logic              r_ovld;
    logic [87:0]       r_odata;

    logic              s_acc, o_free;
    logic [FIRST_W-1:0] first, child;
    logic [ADDR_W-1:0] parent, last, i0;
    logic [VAL_W-1:0]  in_val;
    logic [2:0]        fin_status;
    logic [VAL_W-1:0]  fin_removed, fin_min;

    logic [VAL_W-1:0] c_val [6];
    logic             c_vld [6];
    logic [OFF_W-1:0] c_off [6];
    t_best            b [6];

    assign c_val[0] = r_rdata;
    assign c_vld[0] = r_cv;
    assign c_off[0] = r_coff;
    assign b[5]     = '{vld: 1'b0, val: '0, off: '0};

    for (genvar g = 0; g < 5; g++) begin : g_cell
        hmh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_shv),
            .i_val   (c_val[g]),
            .i_vld   (c_vld[g]),
            .i_off   (c_off[g]),
            .o_val   (c_val[g+1]),
            .o_vld   (c_vld[g+1]),
            .o_off   (c_off[g+1]),
            .i_best  (b[g+1]),
            .o_best  (b[g])
        );
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign o_free = !r_ovld || m_axis_tready;
    assign in_val = s_axis_tdata[VAL_W-1:0];

    assign first  = FIRST_W'({r_pos, 2'b00}) + FIRST_W'(r_pos) + FIRST_W'(1);
    assign child  = first + FIRST_W'(r_k);
    assign parent = div5(r_pos - ADDR_W'(1));
    assign last   = ADDR_W'(r_count - CNT_W'(1));
    assign i0     = (last == '0) ? '0 : div5(last - ADDR_W'(1)) + ADDR_W'(1);

    assign fin_status  = (r_cmd == CMD_REMOVE && r_status == ST_OK && r_rcount == '0)
                         ? ST_NOTFOUND : r_status;
    assign fin_removed = (r_cmd == CMD_REMOVE && r_rcount != '0) ? r_val : r_removed;
    assign fin_min     = (r_count == '0) ? '0 : r_rdata;

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;       n_val = r_val;
        n_v = r_v;           n_mx = r_mx;         n_removed = r_removed;
        n_count = r_count;   n_rcount = r_rcount; n_scan = r_scan;
        n_pos = r_pos;       n_par = r_par;       n_spot = r_spot;
        n_status = r_status; n_moved = r_moved;   n_k = r_k;
        n_coff = r_k;        n_shv = 1'b0;        n_cv = 1'b0;
        mem_we = 1'b0;       mem_wa = r_pos;      mem_wd = r_v;
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_cmd = s_axis_tuser;
                    n_val = in_val;
                    n_rcount = '0;
                    n_removed = '0;
                    n_status = ST_OK;
                    n_moved = 1'b0;
                    n_state = S_FIN;
                    case (s_axis_tuser)
                        CMD_INSERT: begin
                            if (in_val == '0) begin
                                n_status = ST_ZERO;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_v = in_val;
                                n_pos = r_count[ADDR_W-1:0];
                                n_count = r_count + CNT_W'(1);
                                n_state = S_UP;
                            end
                        end
                        CMD_DELMIN: begin
                            if (r_count == '0) n_status = ST_EMPTY;
                            else n_state = S_DM_R0;
                        end
                        CMD_DELMAX: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_scan = CNT_W'(i0);
                                n_mx = '0;
                                n_state = S_MX_R;
                            end
                        end
                        default: begin
                            if (in_val == '0) begin
                                n_status = ST_ZERO;
                            end else begin
                                n_scan = '0;
                                n_state = S_RM_R;
                            end
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                    if (r_cmd == CMD_REMOVE) n_state = r_moved ? S_RM_R : S_DN;
                    else n_state = S_FIN;
                end else begin
                    rd_addr = parent;
                    n_par = parent;
                    n_state = S_UP_W;
                end
            end
            S_UP_W: begin
                mem_we = 1'b1;
                if (r_v < r_rdata) begin
                    mem_wd = r_rdata;
                    n_pos = r_par;
                    n_moved = 1'b1;
                    n_state = S_UP;
                end else if (r_cmd == CMD_REMOVE) begin
                    n_state = r_moved ? S_RM_R : S_DN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN: begin
                if (first >= FIRST_W'(r_count)) begin
                    mem_we = 1'b1;
                    n_state = (r_cmd == CMD_REMOVE) ? S_RM_R : S_FIN;
                end else begin
                    n_k = '0;
                    n_state = S_DN_R;
                end
            end
            S_DN_R: begin
                rd_addr = child[ADDR_W-1:0];
                n_shv = 1'b1;
                n_cv = (child < FIRST_W'(r_count));
                if (r_k == OFF_W'(4)) n_state = S_DN_L;
                else n_k = r_k + OFF_W'(1);
            end
            S_DN_L: n_state = S_DN_C;
            S_DN_C: begin
                mem_we = 1'b1;
                if (r_v > b[0].val) begin
                    mem_wd = b[0].val;
                    n_pos = ADDR_W'(first + FIRST_W'(b[0].off));
                    n_state = S_DN;
                end else begin
                    n_state = (r_cmd == CMD_REMOVE) ? S_RM_R : S_FIN;
                end
            end
            S_DM_R0: n_state = S_DM_W0;
            S_DM_W0: begin
                n_removed = r_rdata;
                rd_addr = last;
                n_state = S_DM_W1;
            end
            S_DM_W1: begin
                n_v = r_rdata;
                n_count = r_count - CNT_W'(1);
                n_rcount = CNT_W'(1);
                n_pos = '0;
                n_state = (r_count == CNT_W'(1)) ? S_FIN : S_DN;
            end
            S_MX_R: begin
                rd_addr = r_scan[ADDR_W-1:0];
                n_state = S_MX_W;
            end
            S_MX_W: begin
                if (r_rdata > r_mx) begin
                    n_mx = r_rdata;
                    n_spot = r_scan[ADDR_W-1:0];
                end
                if (r_scan == r_count - CNT_W'(1)) begin
                    n_v = r_rdata;
                    n_state = S_MX_E;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                    n_state = S_MX_R;
                end
            end
            S_MX_E: begin
                n_removed = r_mx;
                n_rcount = CNT_W'(1);
                n_count = r_count - CNT_W'(1);
                n_pos = r_spot;
                n_moved = 1'b0;
                n_state = (r_v == r_mx) ? S_FIN : S_UP;
            end
            S_RM_R: begin
                rd_addr = r_scan[ADDR_W-1:0];
                n_state = (r_scan >= r_count) ? S_FIN : S_RM_W;
            end
            S_RM_W: begin
                if (r_rdata == r_val) begin
                    n_rcount = r_rcount + CNT_W'(1);
                    n_count = r_count - CNT_W'(1);
                    rd_addr = last;
                    n_state = S_RM_L;
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                    n_state = S_RM_R;
                end
            end
            S_RM_L: begin
                n_v = r_rdata;
                n_pos = r_scan[ADDR_W-1:0];
                n_moved = 1'b0;
                n_state = (r_scan < r_count) ? S_UP : S_RM_R;
            end
            S_FIN: n_state = S_FIN_W;
            S_FIN_W: begin
                if (o_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_shv   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_shv   <= n_shv;
            if (m_axis_tready) r_ovld <= 1'b0;
            if (r_state == S_FIN_W && o_free) r_ovld <= 1'b1;
        end
        r_cmd <= n_cmd;       r_val <= n_val;       r_v <= n_v;
        r_mx <= n_mx;         r_removed <= n_removed;
        r_rcount <= n_rcount; r_scan <= n_scan;     r_pos <= n_pos;
        r_par <= n_par;       r_spot <= n_spot;     r_status <= n_status;
        r_moved <= n_moved;   r_k <= n_k;           r_coff <= n_coff;
        r_cv <= n_cv;
        if (r_state == S_FIN_W && o_free) begin
            r_odata <= {3'b000, r_count, r_rcount, fin_removed, fin_min, fin_status};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

`include "assert_macros.svh"
    `HMH_ASSERT(a_count_cap, r_count <= CNT_W'(CAPACITY), "entry count over capacity")
    `HMH_ASSERT(a_dn_child, (r_state == S_DN_C) |-> b[0].vld, "no valid child in sift-down")
    `HMH_ASSERT(a_acc_busy, s_acc |=> (r_state != S_IDLE), "accepted command left idle")
endmodule
